>>> sv/pme_pkg.sv
package pme_pkg;

	localparam int unsigned DELTA_W = 17;
	localparam int unsigned WHEEL_W = 8;
	localparam int unsigned BTN_W   = 3;
	localparam int unsigned POS_W   = 12;
	localparam int unsigned SIZE_W  = 13;
	localparam int unsigned SPEED_W = 4;
	localparam int unsigned CIDX_W  = 3;

	// event codes on event_kind
	typedef enum logic [1:0] {
		EV_PRESS   = 2'd0,
		EV_RELEASE = 2'd1,
		EV_WHEEL   = 2'd2,
		EV_MOVE    = 2'd3
	} ev_kind_t;

	localparam logic signed [WHEEL_W-1:0] WHEEL_MIN = -8'sd127;
	localparam logic signed [WHEEL_W-1:0] WHEEL_RAW_MIN = -8'sd128;

endpackage

>>> sv/pointer_motion_event_engine.sv
// Pointer motion event engine.
// Batch channel (batch_valid / batch_stall): one accumulated motion batch per
// request, with summed deltas, wheel steps and an optional new raw button set.
// Event channel (event_valid / event_stall): the events caused by each batch,
// in order press-or-release, wheel, move; last_event marks the final one.
// A batch with no button change, no wheel and no motion yields no event.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 speed, 1 accel
// enable, 2 left-handed swap, 3 screen width, 4 screen height. Write only
// while the block is idle; unknown indexes are dropped.
// A taken batch passes the batch register and then the event register
// before its first event shows. The event register sends one event per
// cycle while event_stall is low, and a batch yields up to three events.
// The batch register takes a new request while events are still being sent.
// Stall: while event_stall is high the event register holds, the batch
// register fills and then batch_stall rises. Batches that cause no event
// pass through without waiting.
// Reset (arst_n low): cursor at 0,0, buttons released, registers at speed 1,
// no acceleration, no swap, 1024 x 768 screen; both stages empty.
module pointer_motion_event_engine
	import pme_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	// batch channel
	input  logic                        batch_valid,
	output logic                        batch_stall,
	input  logic signed [DELTA_W-1:0]   delta_x,
	input  logic signed [DELTA_W-1:0]   delta_y,
	input  logic signed [WHEEL_W-1:0]   wheel_delta,
	input  logic                        buttons_valid,
	input  logic [BTN_W-1:0]            new_raw_buttons,
	// event channel
	output logic                        event_valid,
	input  logic                        event_stall,
	output logic [1:0]                  event_kind,
	output logic [POS_W-1:0]            pos_x,
	output logic [POS_W-1:0]            pos_y,
	output logic [BTN_W-1:0]            button_state,
	output logic [BTN_W-1:0]            changed_mask,
	output logic signed [WHEEL_W-1:0]   wheel_out,
	output logic                        last_event,
	// config channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CIDX_W-1:0]           cfg_index,
	input  logic [SIZE_W-1:0]           cfg_data
);

	typedef enum logic [CIDX_W-1:0] {
		CFG_SPEED   = 3'd0,
		CFG_ACCEL   = 3'd1,
		CFG_PRIMARY = 3'd2,
		CFG_WIDTH   = 3'd3,
		CFG_HEIGHT  = 3'd4
	} cfg_idx_t;

	localparam int unsigned SCL_W = DELTA_W + 6;   // scaled delta, signed
	localparam int unsigned SUM_W = SCL_W + 1;     // position before clamp

	// ---------------------------------------------------------------
	// helpers
	// ---------------------------------------------------------------
	// speed multiply, then optional 3/2 (toward zero) or x2
	function automatic logic [SCL_W-1:0] scale_delta(
		input logic signed [DELTA_W-1:0] d,
		input logic [SPEED_W-1:0]        spd,
		input logic                      med,
		input logic                      fast
	);
		logic signed [SCL_W-2:0] s;
		logic signed [SCL_W-1:0] s3;
		logic signed [SCL_W-1:0] s3r;
		logic [SCL_W-1:0]        r;
		s   = (SCL_W-1)'(d) * (SCL_W-1)'($signed({1'b0, spd}));
		s3  = {s[SCL_W-2], s} + {s, 1'b0};
		s3r = s3 + SCL_W'(s3[SCL_W-1]);   // bias negatives: truncate toward zero
		if (fast)
			r = {s, 1'b0};
		else if (med)
			r = s3r >>> 1;
		else
			r = {s[SCL_W-2], s};
		return r;
	endfunction

	// largest coordinate for a screen size; zero acts as one
	function automatic logic [POS_W-1:0] size_lim(input logic [SIZE_W-1:0] sz);
		logic [POS_W-1:0] r;
		if (sz == '0)
			r = '0;
		else if (sz > {1'b1, {POS_W{1'b0}}})
			r = '1;
		else
			r = POS_W'(sz - SIZE_W'(1));
		return r;
	endfunction

	function automatic logic [POS_W-1:0] clamp_pos(
		input logic [SUM_W-1:0] p,
		input logic [POS_W-1:0] lim
	);
		logic [POS_W-1:0] r;
		if (p[SUM_W-1])
			r = '0;
		else if (p > {{(SUM_W-POS_W){1'b0}}, lim})
			r = lim;
		else
			r = p[POS_W-1:0];
		return r;
	endfunction

	function automatic logic [BTN_W-1:0] map_buttons(
		input logic [BTN_W-1:0] b,
		input logic             swap
	);
		return swap ? {b[2], b[0], b[1]} : b;
	endfunction

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic [SPEED_W-1:0] speed_q;
	logic               accel_q;
	logic               primary_q;
	logic [SIZE_W-1:0]  width_q;
	logic [SIZE_W-1:0]  height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q   <= SPEED_W'(1);
			accel_q   <= 1'b0;
			primary_q <= 1'b0;
			width_q   <= SIZE_W'(1024);
			height_q  <= SIZE_W'(768);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SPEED:   speed_q   <= cfg_data[SPEED_W-1:0];
				CFG_ACCEL:   accel_q   <= cfg_data[0];
				CFG_PRIMARY: primary_q <= cfg_data[0];
				CFG_WIDTH:   width_q   <= cfg_data;
				CFG_HEIGHT:  height_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// stage 1: batch register
	// ---------------------------------------------------------------
	logic                      valid_s1;
	logic signed [DELTA_W-1:0] dx_s1;
	logic signed [DELTA_W-1:0] dy_s1;
	logic signed [WHEEL_W-1:0] wh_s1;
	logic                      bv_s1;
	logic [BTN_W-1:0]          raw_s1;

	logic adv_s1;     // stage 1 retires this cycle
	logic free_s2;    // event register can load this cycle
	logic any_ev;

	assign batch_stall = valid_s1 && !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!batch_stall) begin
			valid_s1 <= batch_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (batch_valid && !batch_stall) begin
			dx_s1  <= delta_x;
			dy_s1  <= delta_y;
			wh_s1  <= wheel_delta;
			bv_s1  <= buttons_valid;
			raw_s1 <= new_raw_buttons;
		end
	end

	// ---------------------------------------------------------------
	// stage 1 datapath: motion, clamp, buttons, wheel
	// ---------------------------------------------------------------
	logic [POS_W-1:0] col_q;
	logic [POS_W-1:0] row_q;
	logic [BTN_W-1:0] mapped_q;

	logic [DELTA_W-1:0]        adx, ady, mag;
	logic                      acc_med, acc_fast;
	logic [SCL_W-1:0]          sx, sy;
	logic [SUM_W-1:0]          px, py;
	logic [POS_W-1:0]          col_nxt, row_nxt;
	logic [BTN_W-1:0]          btn_nxt, chg;
	logic signed [WHEEL_W-1:0] wh_sat;
	logic                      has_btn, has_wheel, has_move;

	always_comb begin
		// |dx|, |dy| as unsigned: -65536 maps to 65536
		adx = dx_s1[DELTA_W-1] ? DELTA_W'(-dx_s1) : dx_s1;
		ady = dy_s1[DELTA_W-1] ? DELTA_W'(-dy_s1) : dy_s1;
		mag = (adx > ady) ? adx : ady;
		acc_fast = accel_q && (mag >= DELTA_W'(8));
		acc_med  = accel_q && (mag >= DELTA_W'(4)) && !acc_fast;

		sx = scale_delta(dx_s1, speed_q, acc_med, acc_fast);
		sy = scale_delta(dy_s1, speed_q, acc_med, acc_fast);
		// y grows downward on screen, delta_y grows upward
		px = {{(SUM_W-POS_W){1'b0}}, col_q} + {sx[SCL_W-1], sx};
		py = {{(SUM_W-POS_W){1'b0}}, row_q} - {sy[SCL_W-1], sy};
		col_nxt = clamp_pos(px, size_lim(width_q));
		row_nxt = clamp_pos(py, size_lim(height_q));

		btn_nxt = bv_s1 ? map_buttons(raw_s1, primary_q) : mapped_q;
		chg     = btn_nxt ^ mapped_q;
		wh_sat  = (wh_s1 == WHEEL_RAW_MIN) ? WHEEL_MIN : wh_s1;

		has_btn   = (chg != '0);
		has_wheel = (wh_s1 != '0);
		has_move  = (dx_s1 != '0) || (dy_s1 != '0);
		any_ev    = has_btn || has_wheel || has_move;
	end

	// eventless batches never wait on the event register
	assign adv_s1 = valid_s1 && (free_s2 || !any_ev);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			mapped_q <= '0;
		end else if (adv_s1) begin
			col_q    <= col_nxt;
			row_q    <= row_nxt;
			mapped_q <= btn_nxt;
		end
	end

	// ---------------------------------------------------------------
	// stage 2: event register, drains one pending event each time an event is taken
	// pend bit 0 button, bit 1 wheel, bit 2 move
	// ---------------------------------------------------------------
	logic [2:0]                pend_s2;
	logic                      press_s2;
	logic [BTN_W-1:0]          chg_s2;
	logic signed [WHEEL_W-1:0] wh_s2;
	logic [POS_W-1:0]          col_s2, row_s2;
	logic [BTN_W-1:0]          btn_s2;

	logic [2:0] cur_s2;    // lowest pending event, one-hot
	logic       last_s2;
	logic       take_ev;
	ev_kind_t   kind;

	assign cur_s2  = pend_s2 & (~pend_s2 + 3'd1);
	assign last_s2 = (pend_s2 & (pend_s2 - 3'd1)) == '0;
	assign take_ev = event_valid && !event_stall;
	assign free_s2 = (pend_s2 == '0) || (take_ev && last_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s2 <= '0;
		end else if (adv_s1 && any_ev) begin
			pend_s2 <= {has_move, has_wheel, has_btn};
		end else if (take_ev) begin
			pend_s2 <= pend_s2 & ~cur_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && any_ev) begin
			press_s2 <= (btn_nxt & chg) != '0;
			chg_s2   <= chg;
			wh_s2    <= wh_sat;
			col_s2   <= col_nxt;
			row_s2   <= row_nxt;
			btn_s2   <= btn_nxt;
		end
	end

	always_comb begin
		if (cur_s2[0])
			kind = press_s2 ? EV_PRESS : EV_RELEASE;
		else if (cur_s2[1])
			kind = EV_WHEEL;
		else
			kind = EV_MOVE;
	end

	assign event_valid  = (pend_s2 != '0);
	assign event_kind   = kind;
	assign pos_x        = col_s2;
	assign pos_y        = row_s2;
	assign button_state = btn_s2;
	assign changed_mask = cur_s2[0] ? chg_s2 : '0;
	assign wheel_out    = cur_s2[1] ? wh_s2 : '0;
	assign last_event   = last_s2;

endmodule

>>> sv/pme_checker.sv
module pme_assert_checker
	import pme_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      event_valid,
	input logic                      event_stall,
	input logic [1:0]                event_kind,
	input logic [POS_W-1:0]          pos_x,
	input logic [POS_W-1:0]          pos_y,
	input logic [BTN_W-1:0]          button_state,
	input logic [BTN_W-1:0]          changed_mask,
	input logic signed [WHEEL_W-1:0] wheel_out,
	input logic                      last_event
);

	// stalled event holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && event_stall |=> event_valid && $stable({event_kind, pos_x,
			pos_y, button_state, changed_mask, wheel_out, last_event}))
		else $error("stalled event changed");

	a_mask: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && (event_kind == EV_WHEEL || event_kind == EV_MOVE)
			|-> changed_mask == '0 && (event_kind == EV_WHEEL || wheel_out == '0))
		else $error("mask or wheel set on non-button event");

	a_wheel: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && event_kind == EV_WHEEL
			|-> wheel_out != '0 && wheel_out != WHEEL_RAW_MIN && changed_mask == '0)
		else $error("bad wheel value");

	a_press: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && event_kind == EV_PRESS
			|-> (button_state & changed_mask) != '0 && wheel_out == '0)
		else $error("press without a newly set button");

	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && event_kind == EV_RELEASE
			|-> changed_mask != '0 && (button_state & changed_mask) == '0)
		else $error("release with a changed button still set");

endmodule

bind pointer_motion_event_engine pme_assert_checker u_pme_checker (.*);

>>> verif/pme_tb_pkg.sv
package pme_tb_pkg;

	import pme_pkg::*;

	// register indexes on cfg_index
	typedef enum logic [CIDX_W-1:0] {
		REG_SPEED  = 3'd0,
		REG_ACCEL  = 3'd1,
		REG_SWAP   = 3'd2,
		REG_WIDTH  = 3'd3,
		REG_HEIGHT = 3'd4,
		REG_NONE   = 3'd7
	} cfg_reg_t;

endpackage

>>> verif/pme_checker.sv
module pme_checker
	import pme_pkg::*;
	import pme_tb_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      batch_valid,
	input  logic                      batch_stall,
	input  logic signed [DELTA_W-1:0] delta_x,
	input  logic signed [DELTA_W-1:0] delta_y,
	input  logic signed [WHEEL_W-1:0] wheel_delta,
	input  logic                      buttons_valid,
	input  logic [BTN_W-1:0]          new_raw_buttons,
	input  logic                      event_valid,
	input  logic                      event_stall,
	input  logic [1:0]                event_kind,
	input  logic [POS_W-1:0]          pos_x,
	input  logic [POS_W-1:0]          pos_y,
	input  logic [BTN_W-1:0]          button_state,
	input  logic [BTN_W-1:0]          changed_mask,
	input  logic signed [WHEEL_W-1:0] wheel_out,
	input  logic                      last_event,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [CIDX_W-1:0]         cfg_index,
	input  logic [SIZE_W-1:0]         cfg_data,
	input  logic                      end_of_test,
	output int                        n_pending,
	output int                        n_errors
);

	localparam longint ACCEL_MID   = 4;
	localparam longint ACCEL_FAST  = 8;
	localparam longint MID_NUM     = 3;
	localparam longint MID_DEN     = 2;
	localparam longint FAST_GAIN   = 2;
	localparam longint POS_LIMIT   = 4095;

	typedef struct {
		ev_kind_t                  kind;
		logic [POS_W-1:0]          x;
		logic [POS_W-1:0]          y;
		logic [BTN_W-1:0]          buttons;
		logic [BTN_W-1:0]          changed;
		logic signed [WHEEL_W-1:0] wheel;
		logic                      last;
	} pointer_event_t;

	pointer_event_t pending_events[$];

	logic [SPEED_W-1:0] speed;
	logic               accel_on;
	logic               swap_lr;
	logic [SIZE_W-1:0]  width_px;
	logic [SIZE_W-1:0]  height_px;
	logic [POS_W-1:0]   col;
	logic [POS_W-1:0]   row;
	logic [BTN_W-1:0]   eff_btn;

	task automatic report_mismatch(string what);
		n_errors++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	function automatic longint scaled_motion(longint d, longint mag);
		longint s;
		s = d * longint'(speed);
		if (!accel_on || mag < ACCEL_MID)
			return s;
		if (mag < ACCEL_FAST)
			return (s * MID_NUM) / MID_DEN;
		return s * FAST_GAIN;
	endfunction

	function automatic logic [POS_W-1:0] clamp_to_screen(longint p, logic [SIZE_W-1:0] size);
		longint lim;
		lim = (size == '0) ? 0 : longint'(size) - 1;
		if (lim > POS_LIMIT)
			lim = POS_LIMIT;
		if (p < 0)
			p = 0;
		if (p > lim)
			p = lim;
		return p[POS_W-1:0];
	endfunction

	function automatic logic [BTN_W-1:0] map_raw(logic [BTN_W-1:0] b);
		if (!swap_lr)
			return b;
		return {b[2], b[0], b[1]};
	endfunction

	task automatic advance_pointer(input logic signed [DELTA_W-1:0] dx_in,
			input logic signed [DELTA_W-1:0] dy_in, input logic signed [WHEEL_W-1:0] wh_in,
			input logic bv, input logic [BTN_W-1:0] raw);
		longint dx, dy, mag;
		logic [BTN_W-1:0] prev, chg;
		pointer_event_t ev;
		pointer_event_t batch_evs[$];
		dx = dx_in;
		dy = dy_in;
		mag = (dx < 0) ? -dx : dx;
		if (((dy < 0) ? -dy : dy) > mag)
			mag = (dy < 0) ? -dy : dy;
		col = clamp_to_screen(longint'(col) + scaled_motion(dx, mag), width_px);
		row = clamp_to_screen(longint'(row) - scaled_motion(dy, mag), height_px);
		prev = eff_btn;
		if (bv)
			eff_btn = map_raw(raw);
		chg = prev ^ eff_btn;
		ev.kind = EV_MOVE;
		ev.x = col;
		ev.y = row;
		ev.buttons = eff_btn;
		ev.changed = '0;
		ev.wheel = '0;
		ev.last = 1'b0;
		if (chg != '0) begin
			ev.kind = ((eff_btn & chg) != '0) ? EV_PRESS : EV_RELEASE;
			ev.changed = chg;
			batch_evs.push_back(ev);
			ev.changed = '0;
		end
		if (wh_in != '0) begin
			ev.kind = EV_WHEEL;
			ev.wheel = (wh_in == WHEEL_RAW_MIN) ? WHEEL_MIN : wh_in;
			batch_evs.push_back(ev);
			ev.wheel = '0;
		end
		if (dx != 0 || dy != 0) begin
			ev.kind = EV_MOVE;
			batch_evs.push_back(ev);
		end
		if (batch_evs.size() != 0)
			batch_evs[batch_evs.size()-1].last = 1'b1;
		foreach (batch_evs[i])
			pending_events.push_back(batch_evs[i]);
	endtask

	task automatic check_field(string field, logic [POS_W-1:0] got, logic [POS_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", field, got, want));
	endtask

	task automatic check_event();
		pointer_event_t want;
		if (pending_events.size() == 0) begin
			report_mismatch($sformatf("unexpected event kind %0d at %0d,%0d",
				event_kind, pos_x, pos_y));
			return;
		end
		want = pending_events.pop_front();
		check_field("event_kind", event_kind, want.kind);
		check_field("pos_x", pos_x, want.x);
		check_field("pos_y", pos_y, want.y);
		check_field("button_state", button_state, want.buttons);
		check_field("changed_mask", changed_mask, want.changed);
		check_field("wheel_out", wheel_out, want.wheel);
		check_field("last_event", last_event, want.last);
	endtask

	task automatic write_setting(logic [CIDX_W-1:0] idx, logic [SIZE_W-1:0] data);
		case (cfg_reg_t'(idx))
			REG_SPEED:  speed = data[SPEED_W-1:0];
			REG_ACCEL:  accel_on = data[0];
			REG_SWAP:   swap_lr = data[0];
			REG_WIDTH:  width_px = data;
			REG_HEIGHT: height_px = data;
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed = 1;
			accel_on = 1'b0;
			swap_lr = 1'b0;
			width_px = 1024;
			height_px = 768;
			col = '0;
			row = '0;
			eff_btn = '0;
			pending_events.delete();
		end else begin
			// an event taken now belongs to an older batch than one accepted now
			if (event_valid && !event_stall)
				check_event();
			if (batch_valid && !batch_stall)
				advance_pointer(delta_x, delta_y, wheel_delta, buttons_valid, new_raw_buttons);
			if (cfg_valid && cfg_ready)
				write_setting(cfg_index, cfg_data);
			if (end_of_test && pending_events.size() != 0) begin
				report_mismatch($sformatf("%0d events never arrived", pending_events.size()));
				pending_events.delete();
			end
		end
		n_pending <= pending_events.size();
	end

endmodule

>>> verif/tb_pointer_motion_event_engine.sv
module tb_pointer_motion_event_engine;

	import pme_pkg::*;
	import pme_tb_pkg::*;

	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 9;
	localparam int SETTLE_CYCLES = 6;      // first event shows after the batch and event registers
	localparam int DRAIN_LIMIT   = 20000;
	localparam int HOLD_CYCLES   = 80;     // long receiver hold-off, fills both stages
	localparam int TIMEOUT       = 1000000;
	localparam int RAND_PHASES   = 6;
	localparam int PHASE_ITEMS   = 13;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      batch_valid;
	logic                      batch_stall;
	logic signed [DELTA_W-1:0] delta_x;
	logic signed [DELTA_W-1:0] delta_y;
	logic signed [WHEEL_W-1:0] wheel_delta;
	logic                      buttons_valid;
	logic [BTN_W-1:0]          new_raw_buttons;
	logic                      event_valid;
	logic                      event_stall;
	logic [1:0]                event_kind;
	logic [POS_W-1:0]          pos_x;
	logic [POS_W-1:0]          pos_y;
	logic [BTN_W-1:0]          button_state;
	logic [BTN_W-1:0]          changed_mask;
	logic signed [WHEEL_W-1:0] wheel_out;
	logic                      last_event;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CIDX_W-1:0]         cfg_index;
	logic [SIZE_W-1:0]         cfg_data;
	logic                      end_of_test;
	int                        n_pending;
	int                        n_errors;

	// idle rates in percent, changed per phase by the stimulus
	int tx_pct = 38;
	int rx_pct = 77;
	// bumped by the stimulus to ask the receiver for one long hold-off
	int hold_reqs = 0;

	always #HALF_PERIOD clk = ~clk;

	pointer_motion_event_engine u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.batch_valid     (batch_valid),
		.batch_stall     (batch_stall),
		.delta_x         (delta_x),
		.delta_y         (delta_y),
		.wheel_delta     (wheel_delta),
		.buttons_valid   (buttons_valid),
		.new_raw_buttons (new_raw_buttons),
		.event_valid     (event_valid),
		.event_stall     (event_stall),
		.event_kind      (event_kind),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.button_state    (button_state),
		.changed_mask    (changed_mask),
		.wheel_out       (wheel_out),
		.last_event      (last_event),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	pme_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.batch_valid     (batch_valid),
		.batch_stall     (batch_stall),
		.delta_x         (delta_x),
		.delta_y         (delta_y),
		.wheel_delta     (wheel_delta),
		.buttons_valid   (buttons_valid),
		.new_raw_buttons (new_raw_buttons),
		.event_valid     (event_valid),
		.event_stall     (event_stall),
		.event_kind      (event_kind),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.button_state    (button_state),
		.changed_mask    (changed_mask),
		.wheel_out       (wheel_out),
		.last_event      (last_event),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.end_of_test     (end_of_test),
		.n_pending       (n_pending),
		.n_errors        (n_errors)
	);

	// Event receiver: random stall at rx_pct, or a long counted hold-off on request.
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		event_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				event_stall <= 1'b1;
				hold_left--;
			end else if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				hold_left = HOLD_CYCLES - 1;
				event_stall <= 1'b1;
			end else begin
				event_stall <= ($urandom_range(0, 99) < rx_pct);
			end
		end
	end

	// Offer one batch request. valid is only lowered when a gap follows, so a
	// back-to-back request never sees valid dropped and raised in one step.
	task automatic send_batch(input int dx, input int dy, input int wh, input bit bv,
			input int raw);
		if ($urandom_range(0, 99) < tx_pct) begin
			batch_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < tx_pct);
		end
		batch_valid     <= 1'b1;
		delta_x         <= dx[DELTA_W-1:0];
		delta_y         <= dy[DELTA_W-1:0];
		wheel_delta     <= wh[WHEEL_W-1:0];
		buttons_valid   <= bv;
		new_raw_buttons <= raw[BTN_W-1:0];
		do @(posedge clk); while (batch_stall);
	endtask

	// Drop valid after the last request of a run; call right after send_batch.
	task automatic batch_quiet();
		batch_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait for every predicted event, then settle in case a batch with
	// no events is still in the pipe.
	task automatic wait_events_done();
		int guard;
		guard = 0;
		@(posedge clk);
		while (n_pending != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_reg_t idx, input logic [SIZE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Block must be idle here.
	task automatic set_screen(input int spd, input bit accel, input bit swap, input int w,
			input int h);
		cfg_write(REG_SPEED, spd[SIZE_W-1:0]);
		cfg_write(REG_ACCEL, {{(SIZE_W-1){1'b0}}, accel});
		cfg_write(REG_SWAP, {{(SIZE_W-1){1'b0}}, swap});
		cfg_write(REG_WIDTH, w[SIZE_W-1:0]);
		cfg_write(REG_HEIGHT, h[SIZE_W-1:0]);
	endtask

	function automatic int pick_size();
		case ($urandom_range(0, 3))
			0: return $urandom_range(1, 16);
			1: return $urandom_range(1, 4096);
			2: return 4096;
			default: return $urandom_range(1024, 4096);
		endcase
	endfunction

	// Mostly small deltas around the acceleration thresholds, some full range,
	// some motionless batches; wheel often zero, sometimes the raw minimum.
	task automatic random_batch();
		int dx, dy, wh;
		case ($urandom_range(0, 9))
			0: begin
				dx = $urandom;
				dy = $urandom;
			end
			1: begin
				dx = 0;
				dy = 0;
			end
			default: begin
				dx = int'($urandom_range(0, 24)) - 12;
				dy = int'($urandom_range(0, 24)) - 12;
			end
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: wh = 0;
			5: wh = -128;
			default: wh = $urandom;
		endcase
		send_batch(dx, dy, wh, $urandom_range(0, 1), $urandom_range(0, 7));
	endtask

	initial begin
		arst_n          <= 1'b0;
		batch_valid     <= 1'b0;
		delta_x         <= '0;
		delta_y         <= '0;
		wheel_delta     <= '0;
		buttons_valid   <= 1'b0;
		new_raw_buttons <= '0;
		cfg_valid       <= 1'b0;
		cfg_index       <= '0;
		cfg_data        <= '0;
		end_of_test     <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: speed 1, no accel, no swap, 1024 x 768
		send_batch(65535, 0, 0, 0, 0);       // x clamps at right edge
		send_batch(-65536, 0, 0, 0, 0);      // x clamps at zero
		send_batch(0, -65536, 0, 0, 0);      // downward, y clamps at bottom
		send_batch(0, 65535, 0, 0, 0);       // upward, y clamps at zero
		send_batch(0, 0, 0, 1, 7);           // all buttons pressed
		send_batch(0, 0, 0, 1, 0);           // all released
		send_batch(3, -2, -128, 1, 1);       // press, saturated wheel, move
		send_batch(0, 0, 127, 0, 0);         // wheel only
		send_batch(0, 0, 0, 0, 6);           // buttons not valid, no events
		send_batch(0, 0, 0, 0, 0);           // empty batch
		send_batch(0, 0, 0, 1, 3);           // press of right
		send_batch(0, 0, 0, 1, 2);           // release of left
		send_batch(0, 0, -1, 1, 5);          // mixed change counts as press
		send_batch(0, 0, 0, 1, 5);           // same buttons again, nothing
		batch_quiet();
		wait_events_done();

		cfg_write(REG_NONE, '1);             // unknown index, dropped
		set_screen(15, 1'b1, 1'b1, 4096, 4096);
		send_batch(3, -3, 0, 1, 1);          // just below accel threshold, swapped
		send_batch(4, 0, 0, 0, 0);           // 3/2 band lower edge
		send_batch(-5, 7, 0, 1, 2);          // 3/2 band top, truncation toward zero
		send_batch(8, -8, 0, 1, 4);          // doubling band
		send_batch(65535, -65536, 0, 0, 0);  // clamps at 4095 both ways
		batch_quiet();
		wait_events_done();

		// zero speed, zero width, oversize height
		set_screen(0, 1'b1, 1'b0, 0, 8191);
		send_batch(100, -100, 5, 1, 3);      // move event though nothing moves
		send_batch(-1, 1, 0, 0, 0);
		batch_quiet();
		wait_events_done();
		cfg_write(REG_SPEED, 2);
		send_batch(-3000, -3000, 0, 0, 0);   // y pinned at 4095 by the position width
		batch_quiet();
		wait_events_done();

		for (int p = 0; p < RAND_PHASES; p++) begin
			tx_pct = (p < 2) ? 38 : (p < 4) ? 77 : 0;
			rx_pct = (p < 2) ? 77 : (p < 4) ? 38 : 0;
			if (p == 0)
				set_screen(1, 1'b0, 1'b1, 1, 4096);
			else
				set_screen($urandom_range(1, 15), $urandom_range(0, 1), $urandom_range(0, 1),
					pick_size(), pick_size());
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 1 && i == 4)
					hold_reqs++;
				if (p == 3 && i == 8) begin
					// sender pause until the event queue has drained
					batch_quiet();
					wait_events_done();
				end
				random_batch();
			end
			batch_quiet();
			wait_events_done();
		end

		end_of_test <= 1'b1;
		repeat (2) @(posedge clk);
		if (n_errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#(TIMEOUT);
		$display("TEST FAILED");
		$finish;
	end

endmodule

>>> files.f
sv/pme_pkg.sv
sv/pointer_motion_event_engine.sv
sv/pme_checker.sv
verif/pme_tb_pkg.sv
verif/pme_checker.sv
verif/tb_pointer_motion_event_engine.sv
